// ===== design/fle_pkg.sv =====
package fle_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic [7:0] switch_number;
      logic [3:0] press_code;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] tx_byte;
      logic [7:0] command;
      logic [2:0] data_count;
      logic [7:0] data_a;
      logic [7:0] data_b;
      logic [7:0] data_c;
      logic [7:0] data_d;
      logic [7:0] data_e;
      logic [1:0] timer_action;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] ack_code;
      logic [7:0] nack_code;
      logic [3:0] retry_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_READ,
      ST_CMD
   } state_type;

   localparam logic       REQ_BYTE  = 1'b0;
   localparam logic       REQ_PRESS = 1'b1;

   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_CMD    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] TIMER_NONE  = 2'd0;
   localparam logic [1:0] TIMER_START = 2'd1;
   localparam logic [1:0] TIMER_STOP  = 2'd2;

   localparam logic [2:0] REG_START_MARKER = 3'd0;
   localparam logic [2:0] REG_END_MARKER   = 3'd1;
   localparam logic [2:0] REG_ACK_CODE     = 3'd2;
   localparam logic [2:0] REG_NACK_CODE    = 3'd3;
   localparam logic [2:0] REG_RETRY_LIMIT  = 3'd4;

   localparam logic [7:0] RST_START_MARKER = 8'd2;
   localparam logic [7:0] RST_END_MARKER   = 8'd3;
   localparam logic [7:0] RST_ACK_CODE     = 8'd6;
   localparam logic [7:0] RST_NACK_CODE    = 8'd21;
   localparam logic [3:0] RST_RETRY_LIMIT  = 4'd3;

   localparam logic [7:0] CMD_BASE       = 8'hB0;
   localparam logic [7:0] TX_FRAME_LEN   = 8'd5;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
   localparam logic [2:0] MAX_DATA       = 3'd5;
   localparam logic [2:0] LAST_TX_IDX    = 3'd4;

endpackage

// ===== design/fle_store.sv =====
module fle_store
   import fle_pkg::*;
#(
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fle_ctrl.sv =====
module fle_ctrl
   import fle_pkg::*;
#(
   parameter int FRAME_DEPTH = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  req_type                        req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rsp_type                        rsp_data,
   output logic                           wr_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           rd_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                     rd_data
);

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int CW = $clog2(FRAME_DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] length_ff, length_in;
   logic [3:0]    resend_ff, resend_in;
   logic [7:0]    switch_ff, switch_in;
   logic [3:0]    press_ff, press_in;
   logic          saved_ff, saved_in;
   logic [2:0]    tx_idx_ff, tx_idx_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cap_ptr_ff, cap_ptr_in;
   logic          pend_ff, pend_in;
   logic [2:0]    n_ff, n_in;
   logic [7:0]    slot_ff [6];
   logic [7:0]    slot_in [6];
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic          accept;
   logic          out_free;
   logic          out_load;
   rsp_type       out_next;
   logic [7:0]    rx;
   logic          is_start;
   logic          is_ack;
   logic          is_nack;
   logic          is_end;
   logic [3:0]    resend_clr;
   logic          can_resend;
   logic          len_bad;
   logic [CW-1:0] count_inc;
   logic          frame_done;
   logic [CW-1:0] data_len;
   logic [2:0]    data_n;
   logic [CW-1:0] rd_end;
   logic [CW-1:0] slot_pos;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign rx         = req_data.rx_byte;
   assign is_start   = rx == cfg.start_marker;
   assign is_ack     = rx == cfg.ack_code;
   assign is_nack    = rx == cfg.nack_code;
   assign is_end     = rx == cfg.end_marker;
   assign resend_clr = (is_ack && !is_start) ? 4'd0 : resend_ff;
   assign can_resend = saved_ff && (resend_clr < cfg.retry_limit);
   assign len_bad    = (rx < FRAME_OVERHEAD) || (rx > 8'(FRAME_DEPTH));
   assign count_inc  = count_ff + CW'(1);
   assign frame_done = count_inc >= length_ff;
   assign data_len   = length_ff - CW'(FRAME_OVERHEAD);
   assign data_n     = (data_len > CW'(MAX_DATA)) ? MAX_DATA : data_len[2:0];
   assign rd_end     = CW'(2) + CW'(n_ff);
   assign slot_pos   = cap_ptr_ff - CW'(2);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == REQ_PRESS) begin
                  state_in = ST_SEND;
               end else if (count_ff == CW'(0)) begin
                  if (is_nack && can_resend) begin
                     state_in = ST_SEND;
                  end
               end else if (count_ff != CW'(1) && frame_done && is_end) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SEND: begin
            if (out_free && tx_idx_ff == LAST_TX_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (pend_ff && cap_ptr_ff == rd_end) begin
               state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      length_in  = length_ff;
      resend_in  = resend_ff;
      switch_in  = switch_ff;
      press_in   = press_ff;
      saved_in   = saved_ff;
      tx_idx_in  = tx_idx_ff;
      rd_ptr_in  = rd_ptr_ff;
      cap_ptr_in = cap_ptr_ff;
      pend_in    = 1'b0;
      n_in       = n_ff;
      slot_in    = slot_ff;
      out_load   = 1'b0;
      out_next   = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = rx;
      rd_en      = 1'b0;
      rd_addr    = rd_ptr_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == REQ_PRESS) begin
                  switch_in = req_data.switch_number;
                  press_in  = req_data.press_code;
                  saved_in  = 1'b1;
                  tx_idx_in = '0;
               end else if (count_ff == CW'(0)) begin
                  wr_en     = 1'b1;
                  wr_addr   = AW'(0);
                  resend_in = resend_clr;
                  if (is_start) begin
                     count_in = CW'(1);
                  end
                  if (is_nack) begin
                     if (can_resend) begin
                        resend_in = resend_clr + 4'd1;
                        tx_idx_in = '0;
                     end else begin
                        out_load              = 1'b1;
                        out_next.out_kind     = KIND_STATUS;
                        out_next.timer_action = TIMER_START;
                        out_next.last         = 1'b1;
                     end
                  end else if (is_ack && !is_start) begin
                     out_load              = 1'b1;
                     out_next.out_kind     = KIND_STATUS;
                     out_next.timer_action = TIMER_STOP;
                     out_next.last         = 1'b1;
                  end
               end else if (count_ff == CW'(1)) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(1);
                  if (len_bad) begin
                     count_in = '0;
                  end else begin
                     length_in = rx[CW-1:0];
                     count_in  = CW'(2);
                  end
               end else begin
                  wr_en    = count_ff < CW'(FRAME_DEPTH);
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_inc;
                  if (frame_done) begin
                     count_in          = '0;
                     out_load          = 1'b1;
                     out_next.out_kind = KIND_TX;
                     if (is_end) begin
                        out_next.tx_byte = cfg.ack_code;
                        n_in             = data_n;
                        rd_ptr_in        = CW'(2);
                     end else begin
                        out_next.tx_byte = cfg.nack_code;
                        out_next.last    = 1'b1;
                     end
                  end
               end
            end
         end
         ST_SEND: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_next.out_kind = KIND_TX;
               tx_idx_in         = tx_idx_ff + 3'd1;
               case (tx_idx_ff)
                  3'd0: out_next.tx_byte = cfg.start_marker;
                  3'd1: out_next.tx_byte = TX_FRAME_LEN;
                  3'd2: out_next.tx_byte = CMD_BASE | {4'b0, press_ff};
                  3'd3: out_next.tx_byte = switch_ff;
                  default: begin
                     out_next.tx_byte      = cfg.end_marker;
                     out_next.timer_action = TIMER_START;
                     out_next.last         = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en      = rd_ptr_ff <= rd_end;
            pend_in    = rd_en;
            cap_ptr_in = rd_ptr_ff;
            rd_ptr_in  = rd_ptr_ff + CW'(1);
            if (pend_ff) begin
               slot_in[slot_pos[2:0]] = rd_data;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               out_load            = 1'b1;
               out_next.out_kind   = KIND_CMD;
               out_next.command    = slot_ff[0];
               out_next.data_count = n_ff;
               out_next.data_a     = (n_ff > 3'd0) ? slot_ff[1] : 8'd0;
               out_next.data_b     = (n_ff > 3'd1) ? slot_ff[2] : 8'd0;
               out_next.data_c     = (n_ff > 3'd2) ? slot_ff[3] : 8'd0;
               out_next.data_d     = (n_ff > 3'd3) ? slot_ff[4] : 8'd0;
               out_next.data_e     = (n_ff > 3'd4) ? slot_ff[5] : 8'd0;
               out_next.last       = 1'b1;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_in       = out_next;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         length_ff    <= '0;
         resend_ff    <= '0;
         switch_ff    <= '0;
         press_ff     <= '0;
         saved_ff     <= 1'b0;
         tx_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         resend_ff    <= resend_in;
         switch_ff    <= switch_in;
         press_ff     <= press_in;
         saved_ff     <= saved_in;
         tx_idx_ff    <= tx_idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      cap_ptr_ff <= cap_ptr_in;
      n_ff       <= n_in;
      slot_ff    <= slot_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== design/framed_link_ack_nack_endpoint_top.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_type: line byte or footswitch press
// rsp_      out        rsp_valid/rsp_ready  rsp_type: tx byte, command or status
// csr_      in         csr_we               csr_index selects register, csr_wdata value
//
// A press or a resend sends the five bytes of a frame, start marker to end marker. A good
// frame end sends an ack byte, then reads the command byte and n data bytes (at most 5)
// through the frame store read port, then sends them as one command response.
// Synchronous active-high reset; the frame store needs no clearing pass.
// A stalled rsp_ready holds the output register and the sequencer behind it.
module framed_link_ack_nack_endpoint_top
   import fle_pkg::*;
#(
   parameter int FRAME_DEPTH = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int AW = $clog2(FRAME_DEPTH);

   cfg_type       cfg_ff, cfg_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_START_MARKER: cfg_in.start_marker = csr_wdata;
            REG_END_MARKER:   cfg_in.end_marker   = csr_wdata;
            REG_ACK_CODE:     cfg_in.ack_code     = csr_wdata;
            REG_NACK_CODE:    cfg_in.nack_code    = csr_wdata;
            REG_RETRY_LIMIT:  cfg_in.retry_limit  = csr_wdata[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= RST_START_MARKER;
         cfg_ff.end_marker   <= RST_END_MARKER;
         cfg_ff.ack_code     <= RST_ACK_CODE;
         cfg_ff.nack_code    <= RST_NACK_CODE;
         cfg_ff.retry_limit  <= RST_RETRY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fle_ctrl #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   fle_store #(
      .DEPTH(FRAME_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule
